>>> rtl/btn_dbnc_pkg.sv
// Package for the button debouncer: register indexes, widths and shared types.
`default_nettype none

package btn_dbnc_pkg;

    // Field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned INDEX_W = 8;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_DEBOUNCE   = 8'd0;
    localparam logic [INDEX_W-1:0] REG_LONG_PRESS = 8'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd800;

    // One button sample
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              raw_pressed;
        logic              arm_ignore;
    } t_sample;

    // One result word
    typedef struct packed {
        logic tap_event;
        logic long_press_event;
        logic stable_pressed;
    } t_result;

    // Timing settings handed to the evaluation core
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_timing;

endpackage

`default_nettype wire

>>> rtl/btn_dbnc_if.sv
// Handshake interfaces: sample input, result output and configuration write.
`default_nettype none

interface btn_dbnc_in_if;
    import btn_dbnc_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ms;
    logic              raw_pressed;
    logic              arm_ignore;

    modport source (output valid, output now_ms, output raw_pressed, output arm_ignore,
                    input ready);
    modport sink   (input valid, input now_ms, input raw_pressed, input arm_ignore,
                    output ready);
endinterface

interface btn_dbnc_out_if;
    logic valid;
    logic ready;
    logic tap_event;
    logic long_press_event;
    logic stable_pressed;

    modport source (output valid, output tap_event, output long_press_event,
                    output stable_pressed, input ready);
    modport sink   (input valid, input tap_event, input long_press_event,
                    input stable_pressed, output ready);
endinterface

interface btn_dbnc_cfg_if;
    import btn_dbnc_pkg::*;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic [CFG_W-1:0]   wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/button_debounce_tap_long_press.sv
// Top level of the button debouncer with tap and long-press detection.
//
// Usage:
//   i_in  : one button sample per word (now_ms, raw_pressed, arm_ignore).
//   o_out : one result word per sample (tap_event, long_press_event,
//           stable_pressed), in sample order.
//   i_cfg : register writes, index 0 = debounce_ms, index 1 = long_press_ms;
//           always ready, write only while no sample is in flight.
// Path: the input register takes the sample, then the result register loads
//   the decision made from it.
// Throughput: one sample per cycle while o_out.ready stays high; the debounce
//   state is read and updated by the logic between the two registers.
// Stall: when o_out.ready is low the result register holds its word, the
//   input register fills behind it, and i_in.ready then drops; nothing is lost.
// Reset: i_rst_n low clears both registers' valid flags, the button state
//   (released, no ignore, all times zero) and loads the timings 30 ms and
//   800 ms.
`default_nettype none

module button_debounce_tap_long_press (
    input  wire              i_clk,
    input  wire              i_rst_n,
    btn_dbnc_in_if.sink      i_in,
    btn_dbnc_out_if.source   o_out,
    btn_dbnc_cfg_if.sink     i_cfg
);
    import btn_dbnc_pkg::*;

    // Configuration registers
    t_timing r_timing;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.debounce_ms   <= DEBOUNCE_RESET;
            r_timing.long_press_ms <= LONG_PRESS_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DEBOUNCE:   r_timing.debounce_ms   <= i_cfg.wdata;
                REG_LONG_PRESS: r_timing.long_press_ms <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    // Handshake chain: result register, then input register
    logic    r_in_valid;
    t_sample r_sample;
    logic    r_out_valid;
    t_result r_result;
    t_result step_result;
    logic    out_free;
    logic    advance;
    logic    in_take;

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign in_take    = i_in.valid && i_in.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample.now_ms      <= i_in.now_ms;
            r_sample.raw_pressed <= i_in.raw_pressed;
            r_sample.arm_ignore  <= i_in.arm_ignore;
        end
    end

    // Decision logic and button state
    btn_dbnc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_sample (r_sample),
        .i_timing (r_timing),
        .o_result (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.tap_event        = r_result.tap_event;
    assign o_out.long_press_event = r_result.long_press_event;
    assign o_out.stable_pressed   = r_result.stable_pressed;

    // Checks
    a_no_double_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.tap_event && r_result.long_press_event))
        else $error("tap and long press in one result");

    a_tap_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.tap_event) |-> !r_result.stable_pressed)
        else $error("tap reported while still pressed");

    a_long_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.long_press_event) |-> r_result.stable_pressed)
        else $error("long press reported while released");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("evaluated sample lost before result register");

endmodule

`default_nettype wire

>>> rtl/btn_dbnc_core.sv
// Debounce state and tap / long-press decision for one sample per cycle while i_step is high.
`default_nettype none

module btn_dbnc_core (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_step,
    input  wire btn_dbnc_pkg::t_sample i_sample,
    input  wire btn_dbnc_pkg::t_timing i_timing,
    output btn_dbnc_pkg::t_result      o_result
);
    import btn_dbnc_pkg::*;

    // Button state
    logic              r_last_raw;
    logic              r_debounced;
    logic              r_ignore;
    logic              r_long_fired;
    logic [TIME_W-1:0] r_change_time;
    logic [TIME_W-1:0] r_press_time;

    logic              n_last_raw;
    logic              n_debounced;
    logic              n_ignore;
    logic              n_long_fired;
    logic [TIME_W-1:0] n_change_time;
    logic [TIME_W-1:0] n_press_time;

    logic              raw_changed;
    logic              settled;
    logic              held_long;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    logic              ignore_now;
    logic              tap;
    logic              lng;

    // Elapsed times, both modulo 2^32
    assign since_change = i_sample.now_ms - r_change_time;
    assign since_press  = i_sample.now_ms - r_press_time;
    assign raw_changed  = i_sample.raw_pressed != r_last_raw;

    // A fresh edge has zero elapsed time; only a zero debounce lets it through
    assign settled = raw_changed ? (i_timing.debounce_ms == '0)
                                 : (since_change >= {{(TIME_W-CFG_W){1'b0}},
                                                     i_timing.debounce_ms});
    assign held_long = since_press >= {{(TIME_W-CFG_W){1'b0}}, i_timing.long_press_ms};
    assign ignore_now = r_ignore | i_sample.arm_ignore;

    // Next state and events
    always_comb begin
        n_last_raw    = i_sample.raw_pressed;
        n_change_time = raw_changed ? i_sample.now_ms : r_change_time;
        n_debounced   = r_debounced;
        n_ignore      = ignore_now;
        n_long_fired  = r_long_fired;
        n_press_time  = r_press_time;
        tap           = 1'b0;
        lng           = 1'b0;
        if (settled) begin
            if (i_sample.raw_pressed != r_debounced) begin
                n_debounced = i_sample.raw_pressed;
                if (ignore_now) begin
                    // swallowed press: its release only leaves ignore mode
                    if (!i_sample.raw_pressed) begin
                        n_ignore = 1'b0;
                    end
                end else if (i_sample.raw_pressed) begin
                    n_press_time = i_sample.now_ms;
                    n_long_fired = 1'b0;
                end else if (!r_long_fired) begin
                    tap = 1'b1;
                end
            end else if (!ignore_now && r_debounced && !r_long_fired && held_long) begin
                n_long_fired = 1'b1;
                lng          = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b0;
            r_debounced   <= 1'b0;
            r_ignore      <= 1'b0;
            r_long_fired  <= 1'b0;
            r_change_time <= '0;
            r_press_time  <= '0;
        end else if (i_step) begin
            r_last_raw    <= n_last_raw;
            r_debounced   <= n_debounced;
            r_ignore      <= n_ignore;
            r_long_fired  <= n_long_fired;
            r_change_time <= n_change_time;
            r_press_time  <= n_press_time;
        end
    end

    assign o_result.tap_event        = tap;
    assign o_result.long_press_event = lng;
    assign o_result.stable_pressed   = n_debounced;

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the button debouncer with tap and long-press detection.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import btn_dbnc_pkg::*;

    // Register index that decodes to nothing; writes to it must be ignored
    localparam logic [INDEX_W-1:0] REG_SPARE = 8'hFF;

    localparam int unsigned RESULT_LATENCY = 2;
    localparam int unsigned SETTLE_CYCLES  = RESULT_LATENCY + 2;
    localparam int unsigned IDLE_LIMIT     = 2000;
    localparam int unsigned PHASE_SAMPLES  = 130;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef enum logic [1:0] {
        STIM_SAMPLE,
        STIM_WRITE,
        STIM_SETTLE
    } t_stim_kind;

    // One entry of the stimulus queue: a sample word, a register write, or a pause
    typedef struct packed {
        t_stim_kind         kind;
        t_sample            smp;
        logic [INDEX_W-1:0] idx;
        logic [CFG_W-1:0]   val;
    } t_stim;

    logic i_clk;
    logic i_rst_n;

    btn_dbnc_in_if  in_if();
    btn_dbnc_out_if out_if();
    btn_dbnc_cfg_if cfg_if();

    button_debounce_tap_long_press u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Stimulus and expected event words
    t_stim   button_q[$];
    t_result event_q[$];

    // Predictor copy of the debouncer state and timing registers
    logic [CFG_W-1:0]  set_debounce;
    logic [CFG_W-1:0]  set_hold;
    logic              raw_seen;
    logic              level_now;
    logic              swallow;
    logic              long_done;
    logic [TIME_W-1:0] change_stamp;
    logic [TIME_W-1:0] hold_start;

    // Generator bookkeeping
    logic [TIME_W-1:0] stamp;
    logic [CFG_W-1:0]  gen_deb;
    logic [CFG_W-1:0]  gen_hold;

    // Handshake bookkeeping
    logic        in_took;
    logic        cfg_took;
    int unsigned src_gap;
    int unsigned stall_left;
    int unsigned settle_wait;
    logic        src_calm;
    logic        snk_calm;
    int unsigned idle_cycles;
    int unsigned cycle_cnt;
    int unsigned mismatches;

    always #5 i_clk = ~i_clk;

    // Expected event word for one sample; updates the predictor state
    function automatic t_result debounce_sample(t_sample s);
        t_result r;
        r = '0;
        if (s.arm_ignore)
            swallow = 1'b1;
        if (s.raw_pressed != raw_seen) begin
            raw_seen     = s.raw_pressed;
            change_stamp = s.now_ms;
        end
        if (TIME_W'(s.now_ms - change_stamp) >= TIME_W'(set_debounce)) begin
            if (s.raw_pressed != level_now) begin
                level_now = s.raw_pressed;
                if (swallow) begin
                    if (!level_now)
                        swallow = 1'b0;
                end else if (level_now) begin
                    hold_start = s.now_ms;
                    long_done  = 1'b0;
                end else if (!long_done) begin
                    r.tap_event = 1'b1;
                end
            end else if (!swallow && level_now && !long_done) begin
                if (TIME_W'(s.now_ms - hold_start) >= TIME_W'(set_hold)) begin
                    long_done          = 1'b1;
                    r.long_press_event = 1'b1;
                end
            end
        end
        r.stable_pressed = level_now;
        return r;
    endfunction

    function automatic void apply_write(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
        if (idx == REG_DEBOUNCE)
            set_debounce = val;
        else if (idx == REG_LONG_PRESS)
            set_hold = val;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned pick_pause(logic calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Time step clustered around a threshold, with the odd huge jump
    function automatic logic [TIME_W-1:0] pick_step(logic [CFG_W-1:0] lim);
        int unsigned l;
        l = 32'(lim);
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3: return $urandom_range(0, l);
            4:       return l;
            5:       return (l == 0) ? 0 : l - 1;
            6:       return l + 1;
            7, 8:    return $urandom_range(l, 2 * l + 5);
            default: return ($urandom_range(0, 3) == 0) ? $urandom
                                                        : $urandom_range(0, 4 * l + 10);
        endcase
    endfunction

    task automatic push_sample(logic [TIME_W-1:0] now, logic raw, logic arm);
        t_stim item;
        item                 = '0;
        item.kind            = STIM_SAMPLE;
        item.smp.now_ms      = now;
        item.smp.raw_pressed = raw;
        item.smp.arm_ignore  = arm;
        stamp                = now;
        button_q.push_back(item);
    endtask

    task automatic push_step(logic [TIME_W-1:0] delta, logic raw, logic arm);
        push_sample(stamp + delta, raw, arm);
    endtask

    // Register write, preceded by a pause until every word has come back
    task automatic push_write(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
        t_stim item;
        item      = '0;
        item.kind = STIM_SETTLE;
        button_q.push_back(item);
        item.kind = STIM_WRITE;
        item.idx  = idx;
        item.val  = val;
        button_q.push_back(item);
        if (idx == REG_DEBOUNCE)
            gen_deb = val;
        else if (idx == REG_LONG_PRESS)
            gen_hold = val;
    endtask

    // One press: optional ignore, bounce, hold, bounce, release
    task automatic press_cycle(inout int unsigned count);
        int unsigned n;
        if ($urandom_range(0, 19) == 0) begin
            push_step(pick_step(gen_deb), 1'b0, 1'b1);
            count++;
        end
        n = $urandom_range(0, 3);
        repeat (n) begin
            push_step($urandom_range(0, gen_deb), 1'($urandom_range(0, 1)), 1'b0);
            count++;
        end
        n = $urandom_range(1, 6);
        repeat (n) begin
            push_step($urandom_range(0, 1) ? pick_step(gen_deb) : pick_step(gen_hold),
                      1'b1, $urandom_range(0, 14) == 0);
            count++;
        end
        n = $urandom_range(0, 2);
        repeat (n) begin
            push_step($urandom_range(0, gen_deb), 1'($urandom_range(0, 1)), 1'b0);
            count++;
        end
        n = $urandom_range(1, 3);
        repeat (n) begin
            push_step(pick_step(gen_deb), 1'b0, 1'b0);
            count++;
        end
    endtask

    // Mostly well-formed presses, some unrelated noise samples
    task automatic random_presses(int unsigned target);
        int unsigned count;
        count = 0;
        while (count < target) begin
            if ($urandom_range(0, 9) == 0) begin
                button_q.push_back('{kind: STIM_SAMPLE,
                                     smp: '{now_ms: $urandom,
                                            raw_pressed: 1'($urandom_range(0, 1)),
                                            arm_ignore: 1'($urandom_range(0, 1))},
                                     idx: '0, val: '0});
                count++;
            end else begin
                press_cycle(count);
            end
        end
    endtask

    task automatic report_mismatch(string why, t_result want, t_result got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected tap=%b long=%b stable=%b, got tap=%b long=%b stable=%b",
                     $time, why, want.tap_event, want.long_press_event, want.stable_pressed,
                     got.tap_event, got.long_press_event, got.stable_pressed);
    endtask

    // Monitor: check result words, then track register writes and samples
    always @(posedge i_clk) begin : capture
        t_result got;
        t_result want;
        t_sample smp;
        in_took  <= in_if.valid && in_if.ready;
        cfg_took <= cfg_if.valid && cfg_if.ready;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got = {out_if.tap_event, out_if.long_press_event, out_if.stable_pressed};
                if (event_q.size() == 0) begin
                    report_mismatch("word with none expected", '0, got);
                end else begin
                    want = event_q.pop_front();
                    if (got.tap_event !== want.tap_event ||
                        got.long_press_event !== want.long_press_event ||
                        got.stable_pressed !== want.stable_pressed)
                        report_mismatch("event word mismatch", want, got);
                end
            end
            if (cfg_if.valid && cfg_if.ready)
                apply_write(cfg_if.index, cfg_if.wdata);
            if (in_if.valid && in_if.ready) begin
                smp = {in_if.now_ms, in_if.raw_pressed, in_if.arm_ignore};
                event_q.push_back(debounce_sample(smp));
            end
        end
    end

    // Driver: sample and register words from the queue, with random gaps
    always @(negedge i_clk) begin : drive_words
        t_stim head;
        logic  in_busy;
        logic  cfg_busy;
        in_busy  = in_if.valid && !in_took;
        cfg_busy = cfg_if.valid && !cfg_took;
        if (i_rst_n && !in_busy && !cfg_busy) begin
            if (src_gap != 0) begin
                src_gap = src_gap - 1;
            end else if (button_q.size() != 0) begin
                head = button_q[0];
                case (head.kind)
                    STIM_SAMPLE: begin
                        head               = button_q.pop_front();
                        in_if.now_ms      <= head.smp.now_ms;
                        in_if.raw_pressed <= head.smp.raw_pressed;
                        in_if.arm_ignore  <= head.smp.arm_ignore;
                        in_busy            = 1'b1;
                        src_gap            = pick_pause(src_calm);
                    end
                    STIM_WRITE: begin
                        head          = button_q.pop_front();
                        cfg_if.index <= head.idx;
                        cfg_if.wdata <= head.val;
                        cfg_busy      = 1'b1;
                    end
                    default: begin
                        // hold off until the pipeline is empty and quiet
                        if (event_q.size() != 0) begin
                            settle_wait = 0;
                        end else if (settle_wait < SETTLE_CYCLES) begin
                            settle_wait++;
                        end else begin
                            settle_wait = 0;
                            head        = button_q.pop_front();
                        end
                    end
                endcase
            end
        end
        in_if.valid  <= in_busy;
        cfg_if.valid <= cfg_busy;
    end

    // Result sink: random stalls
    always @(negedge i_clk) begin : drive_ready
        if (stall_left != 0) begin
            stall_left    = stall_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            stall_left    = pick_pause(snk_calm);
        end
    end

    // Watchdog on handshake activity; also switches quiet stretches on and off
    always @(posedge i_clk) begin : watchdog
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 300 == 0) begin
            src_calm <= ($urandom_range(0, 3) == 0);
            snk_calm <= ($urandom_range(0, 3) == 0);
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.now_ms    = '0;
        in_if.raw_pressed = 1'b0;
        in_if.arm_ignore  = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.wdata    = '0;
        out_if.ready    = 1'b0;
        in_took         = 1'b0;
        cfg_took        = 1'b0;
        src_gap         = 0;
        stall_left      = 0;
        settle_wait     = 0;
        src_calm        = 1'b0;
        snk_calm        = 1'b0;
        idle_cycles     = 0;
        cycle_cnt       = 0;
        mismatches      = 0;

        set_debounce = DEBOUNCE_RESET;
        set_hold     = LONG_PRESS_RESET;
        raw_seen     = 1'b0;
        level_now    = 1'b0;
        swallow      = 1'b0;
        long_done    = 1'b0;
        change_stamp = '0;
        hold_start   = '0;
        gen_deb      = DEBOUNCE_RESET;
        gen_hold     = LONG_PRESS_RESET;
        stamp        = '0;

        // Reset timings: bounce, long press, release after long, tap,
        // ignore armed while held, ignore armed while released
        push_sample(32'd0,    1'b0, 1'b0);
        push_sample(32'd10,   1'b1, 1'b0);
        push_sample(32'd30,   1'b1, 1'b0);
        push_sample(32'd40,   1'b1, 1'b0);
        push_sample(32'd900,  1'b1, 1'b0);
        push_sample(32'd1010, 1'b0, 1'b0);
        push_sample(32'd1040, 1'b0, 1'b0);
        push_sample(32'd1100, 1'b1, 1'b0);
        push_sample(32'd1130, 1'b1, 1'b0);
        push_sample(32'd1200, 1'b0, 1'b0);
        push_sample(32'd1230, 1'b0, 1'b0);
        push_sample(32'd1300, 1'b1, 1'b0);
        push_sample(32'd1330, 1'b1, 1'b0);
        push_sample(32'd1340, 1'b1, 1'b1);
        push_sample(32'd2500, 1'b1, 1'b0);
        push_sample(32'd2510, 1'b0, 1'b0);
        push_sample(32'd2540, 1'b0, 1'b0);
        push_sample(32'd2600, 1'b0, 1'b1);
        push_sample(32'd2610, 1'b1, 1'b0);
        push_sample(32'd2640, 1'b1, 1'b0);
        push_sample(32'd3510, 1'b0, 1'b0);
        push_sample(32'd3540, 1'b0, 1'b0);
        random_presses(PHASE_SAMPLES);

        // Zero debounce and zero hold, timestamps wrapping and going backwards
        push_write(REG_DEBOUNCE, 16'd0);
        push_write(REG_LONG_PRESS, 16'd0);
        push_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
        push_sample(32'h0000_0000, 1'b1, 1'b0);
        push_sample(32'd5, 1'b0, 1'b0);
        push_sample(32'd5, 1'b1, 1'b0);
        push_sample(32'd5, 1'b0, 1'b0);
        push_sample(32'd2, 1'b0, 1'b0);
        random_presses(PHASE_SAMPLES);

        // Largest timings; the spare index must leave them alone
        push_write(REG_DEBOUNCE, 16'hFFFF);
        push_write(REG_LONG_PRESS, 16'hFFFF);
        push_write(REG_SPARE, 16'h0000);
        random_presses(PHASE_SAMPLES);

        push_write(REG_DEBOUNCE, 16'd5);
        push_write(REG_LONG_PRESS, 16'd40);
        random_presses(PHASE_SAMPLES);

        push_write(REG_DEBOUNCE, 16'($urandom_range(0, 300)));
        push_write(REG_LONG_PRESS, 16'($urandom_range(0, 3000)));
        random_presses(PHASE_SAMPLES);

        push_write(REG_DEBOUNCE, 16'd1);
        push_write(REG_LONG_PRESS, 16'd0);
        random_presses(PHASE_SAMPLES);

        push_write(REG_DEBOUNCE, 16'd0);
        push_write(REG_LONG_PRESS, 16'hFFFF);
        random_presses(PHASE_SAMPLES);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all words sent, all results back, then a quiet tail
        while (button_q.size() != 0 || in_if.valid || cfg_if.valid)
            @(posedge i_clk);
        while (event_q.size() != 0)
            @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/btn_dbnc_pkg.sv
rtl/btn_dbnc_if.sv
rtl/btn_dbnc_core.sv
rtl/button_debounce_tap_long_press.sv
sim/testbench.sv
